/* hw/rtl/mlsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsr_pkg
// shared widths, codes and sequencer states of the multi-list swap-remove set
// ----------------------------------------------------------------------------
package mlsr_pkg;

  // item field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned STATUS_W = 2;

  // stream widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = ACTION_W + SEL_W;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_TUSER_W = 1 + STATUS_W;
  localparam int unsigned M_PAD_W   = M_TDATA_W - POS_W - COUNT_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_SCAN    = 3'd1,
    S_MOVE_RD = 3'd2,
    S_MOVE_WR = 3'd3,
    S_DONE    = 3'd4
  } state_e;

endpackage

/* hw/rtl/mlsr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsr_ram
// list storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mlsr_ram #(
  parameter int unsigned ADDR_W = 13,
  parameter int unsigned DATA_W = 10,
  parameter int unsigned DEPTH  = 8192
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/multi_list_swap_remove_set_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_list_swap_remove_set_unit
// per-category packed id lists with add, find, swap-remove and clear
// ----------------------------------------------------------------------------
// usage:
//   one command transfer on the s_axis side (action and list in tuser, id in
//   tdata) gives exactly one result transfer on the m_axis side (found and
//   status in tuser, position and list count in tdata).
//   add and clear go from accept straight to the done state. find and
//   remove scan the list from the newest slot down, one slot per cycle
//   through the single ram read port; a remove that hits below the last
//   entry then reads that entry and moves it into the hole.
//   s_axis_tready is high only while the sequencer is idle; one command is
//   worked on at a time.
//   reset zeroes every fill count; the list ram itself is not cleared, and
//   slots above a fill count are never read.
//   a finished result sits in the output register; if m_axis_tready is low
//   the next command is still taken and runs, and its result waits in the
//   sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module multi_list_swap_remove_set_unit
  import mlsr_pkg::*;
#(
  parameter int unsigned NUM_LISTS     = 8,
  parameter int unsigned LIST_CAPACITY = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // entry_id, zero pad
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // action, list_select
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // position, list_count, zero pad
  output logic [M_TUSER_W-1:0] m_axis_tuser   // found, status
);

  localparam int unsigned LIST_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned SLOT_W    = $clog2(LIST_CAPACITY);
  localparam int unsigned CNT_W     = $clog2(LIST_CAPACITY + 1);
  localparam int unsigned ADDR_W    = LIST_W + SLOT_W;
  localparam int unsigned MEM_DEPTH = NUM_LISTS * (2 ** SLOT_W);
  localparam logic [CNT_W-1:0] CAP  = CNT_W'(LIST_CAPACITY);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  // input unpack
  action_e                   in_action;
  logic [SEL_W-1:0]          in_sel;
  logic [SEL_W+LIST_W-1:0]   in_sel_ext;
  logic [LIST_W-1:0]         in_list;
  logic                      in_sel_ok;
  logic [ID_W-1:0]           in_id;
  logic [CNT_W-1:0]          fill_rd;
  logic [CNT_W-1:0]          fill_m1;

  assign in_action  = action_e'(s_axis_tuser[ACTION_W-1:0]);
  assign in_sel     = s_axis_tuser[ACTION_W +: SEL_W];
  assign in_sel_ext = {{LIST_W{1'b0}}, in_sel};
  assign in_list    = in_sel_ext[LIST_W-1:0];
  assign in_sel_ok  = (32'(in_sel) < NUM_LISTS);
  assign in_id      = s_axis_tdata[ID_W-1:0];

  // sequencer state
  state_e             state_q, state_d;
  logic [LIST_W-1:0]  list_q, list_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic               remove_q, remove_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SLOT_W-1:0]  issue_q, issue_d;
  logic               more_q, more_d;
  logic               pend_q, pend_d;
  logic [SLOT_W-1:0]  pend_slot_q, pend_slot_d;
  logic               found_q, found_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [CNT_W-1:0]   rcnt_q, rcnt_d;
  status_e            status_q, status_d;

  logic [CNT_W-1:0]   cnt_m1;
  logic [SLOT_W-1:0]  last_slot;

  // fill counts
  logic [CNT_W-1:0]   fill_q [NUM_LISTS];
  logic               fill_we;
  logic               fill_clr;
  logic [LIST_W-1:0]  fill_idx;
  logic [CNT_W-1:0]   fill_wdata;

  // ram ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ID_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ID_W-1:0]    ram_rdata;

  // output register
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic [M_TUSER_W-1:0] m_tuser_q;
  logic                 m_load;
  logic [SLOT_W+POS_W-1:0]   pos_ext;
  logic [CNT_W+COUNT_W-1:0]  cnt_ext;

  assign fill_rd   = fill_q[in_list];
  assign fill_m1   = fill_rd - ONE;
  assign cnt_m1    = cnt_q - ONE;
  assign last_slot = cnt_m1[SLOT_W-1:0];

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    list_d      = list_q;
    id_d        = id_q;
    remove_d    = remove_q;
    cnt_d       = cnt_q;
    issue_d     = issue_q;
    more_d      = more_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    found_d     = found_q;
    slot_d      = slot_q;
    rcnt_d      = rcnt_q;
    status_d    = status_q;
    fill_we     = 1'b0;
    fill_clr    = 1'b0;
    fill_idx    = list_q;
    fill_wdata  = cnt_m1;
    ram_we      = 1'b0;
    ram_waddr   = {list_q, slot_q};
    ram_wdata   = id_q;
    ram_raddr   = {list_q, issue_q};
    m_load      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          list_d   = in_list;
          id_d     = in_id;
          remove_d = (in_action == ACT_REMOVE);
          found_d  = 1'b0;
          slot_d   = '0;
          rcnt_d   = '0;
          status_d = ST_OK;
          state_d  = S_DONE;
          if (in_action == ACT_CLEAR) begin
            fill_clr = 1'b1;
          end else if (!in_sel_ok) begin
            if (in_action == ACT_ADD) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_MISS;
            end
          end else if (in_action == ACT_ADD) begin
            if (fill_rd < CAP) begin
              ram_we     = 1'b1;
              ram_waddr  = {in_list, fill_rd[SLOT_W-1:0]};
              ram_wdata  = in_id;
              fill_we    = 1'b1;
              fill_idx   = in_list;
              fill_wdata = fill_rd + ONE;
              rcnt_d     = fill_rd + ONE;
            end else begin
              status_d = ST_FULL;
              rcnt_d   = fill_rd;
            end
          end else begin
            cnt_d = fill_rd;
            if (fill_rd == '0) begin
              status_d = ST_MISS;
            end else begin
              issue_d = fill_m1[SLOT_W-1:0];
              more_d  = 1'b1;
              pend_d  = 1'b0;
              state_d = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle, compare the one issued the cycle before
        if (more_q) begin
          pend_d      = 1'b1;
          pend_slot_d = issue_q;
          if (issue_q == '0) begin
            more_d = 1'b0;
          end else begin
            issue_d = issue_q - SLOT_W'(1);
          end
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (ram_rdata == id_q)) begin
          found_d = 1'b1;
          slot_d  = pend_slot_q;
          more_d  = 1'b0;
          pend_d  = 1'b0;
          if (remove_q) begin
            rcnt_d = cnt_m1;
            if (pend_slot_q == last_slot) begin
              // hit on the last entry, nothing to move
              fill_we = 1'b1;
              state_d = S_DONE;
            end else begin
              state_d = S_MOVE_RD;
            end
          end else begin
            rcnt_d  = cnt_q;
            state_d = S_DONE;
          end
        end else if (pend_q && !more_q) begin
          status_d = ST_MISS;
          rcnt_d   = cnt_q;
          pend_d   = 1'b0;
          state_d  = S_DONE;
        end
      end

      S_MOVE_RD: begin
        ram_raddr = {list_q, last_slot};
        state_d   = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        // last entry fills the hole
        ram_we    = 1'b1;
        ram_waddr = {list_q, slot_q};
        ram_wdata = ram_rdata;
        fill_we   = 1'b1;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_load  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      more_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      more_q  <= more_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q      <= list_d;
    id_q        <= id_d;
    remove_q    <= remove_d;
    cnt_q       <= cnt_d;
    issue_q     <= issue_d;
    pend_slot_q <= pend_slot_d;
    found_q     <= found_d;
    slot_q      <= slot_d;
    rcnt_q      <= rcnt_d;
    status_q    <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (fill_clr) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (fill_we) begin
      fill_q[fill_idx] <= fill_wdata;
    end
  end

  mlsr_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (ID_W),
    .DEPTH  (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result formatting to the fixed field widths
  assign pos_ext = {{POS_W{1'b0}}, slot_q};
  assign cnt_ext = {{COUNT_W{1'b0}}, rcnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_tdata_q <= {{M_PAD_W{1'b0}}, cnt_ext[COUNT_W-1:0], pos_ext[POS_W-1:0]};
      m_tuser_q <= {status_q, found_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  // checks
  a_scan_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q != '0))
    else $error("scan running on an empty list");

  a_pend_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q) |-> (pend_slot_q < cnt_q))
    else $error("scan compared a slot beyond the fill count");

  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE || state_q == S_MOVE_WR))
    else $error("list ram written outside add or move");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command taken while the previous one is in flight");

endmodule
